FILE: rtl/rc4sc_pkg.sv
// Package for the RC4 stream cipher core: table size, key defaults and word types.
// Depends on nothing; used by rc4_stream_cipher_core.
package rc4sc_pkg;

  localparam int unsigned TABLE_SIZE = 256;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned KEY_MAX_BYTES_DEF = 256;

  localparam logic OP_KEY_LOAD = 1'b0;
  localparam logic OP_DATA = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [BYTE_W-1:0] key_byte;
    logic              key_last;
    logic [BYTE_W-1:0] plain_byte;
  } in_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] cipher_byte;
    logic [BYTE_W-1:0] keystream_byte;
    logic              not_keyed;
  } out_word_t;

endpackage

FILE: rtl/rc4_stream_cipher_core.sv
// RC4 stream cipher core: key store, permutation table RAM and the sequencer that
// runs key schedule and keystream generation. Depends on rc4sc_pkg.
//
// Channel  Direction  Handshake                  Word
// in       input      in_valid_i / in_ready_o    in_data_i  (rc4sc_pkg::in_word_t)
// out      output     out_valid_o / out_ready_i  out_data_o (rc4sc_pkg::out_word_t)
//
// A keyed data word passes through the accept cycle and three table RAM steps
// (read S[i], read S[j], two swap writes with the keystream read between them).
// Key-load words are accepted in the idle state; the last one adds the key schedule,
// 256 steps through the states KRD, KACC, KW1 and KW2, set by the single table RAM port.
// Reset makes the table the identity through per-entry valid bits; no clearing pass.
// A waiting output word is held in the output register; a new input word is taken in
// the idle state when that register is empty or being emptied in the same cycle.
module rc4_stream_cipher_core
  import rc4sc_pkg::*;
#(
  parameter int unsigned KEY_MAX_BYTES = KEY_MAX_BYTES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  localparam int unsigned KIW = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;
  localparam int unsigned KCW = $clog2(KEY_MAX_BYTES + 1);
  localparam int unsigned TIW = $clog2(TABLE_SIZE);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DJ   = 3'd1;
  localparam logic [2:0] ST_DSW  = 3'd2;
  localparam logic [2:0] ST_DWJ  = 3'd3;
  localparam logic [2:0] ST_KRD  = 3'd4;
  localparam logic [2:0] ST_KACC = 3'd5;
  localparam logic [2:0] ST_KW1  = 3'd6;
  localparam logic [2:0] ST_KW2  = 3'd7;

  logic [2:0] state_q, state_d;

  logic [BYTE_W-1:0] perm_mem [TABLE_SIZE];
  logic [BYTE_W-1:0] key_mem [KEY_MAX_BYTES];
  logic [TABLE_SIZE-1:0] valid_q, valid_d;

  logic [BYTE_W-1:0] rd_data_q;
  logic [TIW-1:0]    rd_addr_q;
  logic              rd_valid_q;
  logic [BYTE_W-1:0] key_rd_q;
  logic [BYTE_W-1:0] s_rd;

  logic [TIW-1:0] raddr;
  logic           we;
  logic [TIW-1:0] waddr;
  logic [BYTE_W-1:0] wdata;
  logic           clear_valid;

  logic           key_we;
  logic [KIW-1:0] key_waddr;

  logic [KCW-1:0] key_count_q, key_count_d;
  logic           key_ready_q, key_ready_d;
  logic           key_loading_q, key_loading_d;
  logic [TIW-1:0] idx_i_q, idx_i_d;
  logic [TIW-1:0] idx_j_q, idx_j_d;
  logic [TIW-1:0] n_q, n_d;
  logic [KIW-1:0] p_q, p_d;
  logic [BYTE_W-1:0] acc_q, acc_d;
  logic [BYTE_W-1:0] a_q, a_d;
  logic [BYTE_W-1:0] b_q, b_d;
  logic [TIW-1:0] t_q, t_d;
  logic [BYTE_W-1:0] b_plain_q;

  logic      out_valid_q, out_valid_d;
  out_word_t out_q, out_d;

  logic           in_fire;
  logic [KCW-1:0] cnt_eff;
  logic [KCW-1:0] p_inc;
  logic [BYTE_W-1:0] acc_new;
  logic [BYTE_W-1:0] ks;

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  assign s_rd = rd_valid_q ? rd_data_q : BYTE_W'(rd_addr_q);
  assign cnt_eff = key_loading_q ? key_count_q : '0;
  assign p_inc = KCW'(p_q) + KCW'(1);
  assign acc_new = acc_q + s_rd + key_rd_q;
  assign ks = (t_q == idx_j_q) ? a_q : ((t_q == idx_i_q) ? b_q : s_rd);

  always_comb begin
    state_d = state_q;
    key_count_d = key_count_q;
    key_ready_d = key_ready_q;
    key_loading_d = key_loading_q;
    idx_i_d = idx_i_q;
    idx_j_d = idx_j_q;
    n_d = n_q;
    p_d = p_q;
    acc_d = acc_q;
    a_d = a_q;
    b_d = b_q;
    t_d = t_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d = out_q;
    raddr = n_q;
    we = 1'b0;
    waddr = n_q;
    wdata = b_q;
    clear_valid = 1'b0;
    key_we = 1'b0;
    key_waddr = cnt_eff[KIW-1:0];

    case (state_q)
      ST_IDLE: begin
        raddr = idx_i_q + TIW'(1);
        if (in_fire) begin
          if (in_data_i.operation == OP_KEY_LOAD) begin
            key_loading_d = 1'b1;
            key_ready_d = 1'b0;
            key_count_d = cnt_eff;
            if (cnt_eff < KCW'(KEY_MAX_BYTES)) begin
              key_we = 1'b1;
              key_count_d = cnt_eff + KCW'(1);
            end
            if (in_data_i.key_last) begin
              key_loading_d = 1'b0;
              clear_valid = 1'b1;
              idx_i_d = '0;
              idx_j_d = '0;
              n_d = '0;
              p_d = '0;
              acc_d = '0;
              state_d = ST_KRD;
            end
          end else if (!key_ready_q) begin
            out_valid_d = 1'b1;
            out_d.cipher_byte = in_data_i.plain_byte;
            out_d.keystream_byte = '0;
            out_d.not_keyed = 1'b1;
          end else begin
            idx_i_d = idx_i_q + TIW'(1);
            state_d = ST_DJ;
          end
        end
      end
      ST_DJ: begin
        a_d = s_rd;
        idx_j_d = idx_j_q + s_rd;
        raddr = idx_j_q + s_rd;
        state_d = ST_DSW;
      end
      ST_DSW: begin
        b_d = s_rd;
        we = 1'b1;
        waddr = idx_i_q;
        wdata = s_rd;
        t_d = a_q + s_rd;
        raddr = a_q + s_rd;
        state_d = ST_DWJ;
      end
      ST_DWJ: begin
        we = 1'b1;
        waddr = idx_j_q;
        wdata = a_q;
        out_valid_d = 1'b1;
        out_d.cipher_byte = b_plain_q ^ ks;
        out_d.keystream_byte = ks;
        out_d.not_keyed = 1'b0;
        state_d = ST_IDLE;
      end
      ST_KRD: begin
        raddr = n_q;
        state_d = ST_KACC;
      end
      ST_KACC: begin
        a_d = s_rd;
        acc_d = acc_new;
        raddr = acc_new;
        state_d = ST_KW1;
      end
      ST_KW1: begin
        we = 1'b1;
        waddr = n_q;
        wdata = s_rd;
        state_d = ST_KW2;
      end
      ST_KW2: begin
        we = 1'b1;
        waddr = acc_q;
        wdata = a_q;
        n_d = n_q + TIW'(1);
        p_d = (p_inc >= key_count_q) ? '0 : p_inc[KIW-1:0];
        if (n_q == TIW'(TABLE_SIZE - 1)) begin
          key_ready_d = 1'b1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_KRD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      b_plain_q <= in_data_i.plain_byte;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (clear_valid) begin
      valid_d = '0;
    end else if (we) begin
      valid_d[waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      perm_mem[waddr] <= wdata;
    end
    rd_data_q <= perm_mem[raddr];
    rd_addr_q <= raddr;
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_waddr] <= in_data_i.key_byte;
    end
    key_rd_q <= key_mem[p_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= '0;
      rd_valid_q <= 1'b0;
      key_count_q <= '0;
      key_ready_q <= 1'b0;
      key_loading_q <= 1'b0;
      idx_i_q <= '0;
      idx_j_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      rd_valid_q <= valid_q[raddr];
      key_count_q <= key_count_d;
      key_ready_q <= key_ready_d;
      key_loading_q <= key_loading_d;
      idx_i_q <= idx_i_d;
      idx_j_q <= idx_j_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d;
    p_q <= p_d;
    acc_q <= acc_d;
    a_q <= a_d;
    b_q <= b_d;
    t_q <= t_d;
    out_q <= out_d;
  end

  // The result register is always free when a keyed data word completes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DWJ) |-> !out_valid_q)
    else $error("result register busy at keystream completion");

  // A complete key is dropped only by an accepted key-load word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(key_ready_q) |-> $past(in_fire && (in_data_i.operation == OP_KEY_LOAD)))
    else $error("key dropped without a key-load word");

  // The key becomes ready only at the last key schedule step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(key_ready_q) |-> ($past(state_q) == ST_KW2) && (state_q == ST_IDLE))
    else $error("key ready outside key schedule end");

  // A result appears only from an unkeyed data word or a finished keystream step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DWJ ||
                                 (in_fire && (in_data_i.operation == OP_DATA) && !key_ready_q)))
    else $error("unexpected result word");

  // The stored key length never passes the maximum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_count_q <= KCW'(KEY_MAX_BYTES))
    else $error("key count above maximum");

endmodule
